// ===== rtl/dps_pkg.sv =====
// Shared constants and types for the depth-first path search unit.
package dps_pkg;

  localparam int unsigned NODES   = 8;
  localparam int unsigned NODE_W  = 3;
  localparam int unsigned SCAN_W  = 4;
  localparam int unsigned DEPTH_W = 4;
  localparam int unsigned ADJ_W   = 64;
  localparam int unsigned BIT_W   = 6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EMIT
  } state_e;

  // Outcome of one neighbor test by the shared edge unit.
  typedef struct packed {
    logic col_done;
    logic push;
    logic hit;
  } edge_res_t;

  // One result offered to the output register.
  typedef struct packed {
    logic              valid;
    logic [NODE_W-1:0] path_node;
    logic              found;
    logic              last;
  } emit_t;

endpackage

// ===== rtl/dps_edge_unit.sv =====
// Shared neighbor test: edge lookup, visited check and target compare.
module dps_edge_unit (
  input  logic [dps_pkg::ADJ_W-1:0]  adj_i,
  input  logic [dps_pkg::NODES-1:0]  visited_i,
  input  logic [dps_pkg::NODE_W-1:0] node_i,
  input  logic [dps_pkg::SCAN_W-1:0] col_i,
  input  logic [dps_pkg::NODE_W-1:0] target_i,
  output dps_pkg::edge_res_t         res_o
);

  logic [dps_pkg::BIT_W-1:0] bit_idx;
  logic                      edge_bit;

  // The row-major bit index is node * NODES + col.
  assign bit_idx  = {node_i, col_i[dps_pkg::NODE_W-1:0]};
  assign edge_bit = adj_i[bit_idx];

  always_comb begin
    res_o.col_done = col_i[dps_pkg::SCAN_W-1];
    res_o.push     = !col_i[dps_pkg::SCAN_W-1] && edge_bit
                     && !visited_i[col_i[dps_pkg::NODE_W-1:0]];
    res_o.hit      = res_o.push && (col_i[dps_pkg::NODE_W-1:0] == target_i);
  end

endmodule

// ===== rtl/dps_seq.sv =====
// Search sequencer: explicit stack, visited marks and path emission.
module dps_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [dps_pkg::ADJ_W-1:0]   adj_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [dps_pkg::NODE_W-1:0]  start_i,
  input  logic [dps_pkg::NODE_W-1:0]  target_i,
  output dps_pkg::emit_t              item_o,
  input  logic                        take_i
);

  dps_pkg::state_e state_q, state_d;

  logic [dps_pkg::NODE_W-1:0]  stk_node_q [dps_pkg::NODES];
  logic [dps_pkg::SCAN_W-1:0]  stk_scan_q [dps_pkg::NODES];
  logic [dps_pkg::DEPTH_W-1:0] depth_q, depth_d;
  logic [dps_pkg::NODES-1:0]   visited_q, visited_d;
  logic [dps_pkg::NODE_W-1:0]  target_q, target_d;
  logic [dps_pkg::NODE_W-1:0]  emit_idx_q, emit_idx_d;
  logic                        found_q, found_d;

  logic [dps_pkg::NODE_W-1:0]  top_idx;
  logic [dps_pkg::NODE_W-1:0]  rd_idx;
  logic [dps_pkg::NODE_W-1:0]  rd_node;
  logic [dps_pkg::SCAN_W-1:0]  rd_scan;
  logic [dps_pkg::NODE_W-1:0]  push_idx;
  logic                        accept;
  logic                        emit_last;
  dps_pkg::edge_res_t          eres;

  // Stack write controls.
  logic                        wr_scan_en;
  logic                        wr_push_en;
  logic [dps_pkg::NODE_W-1:0]  wr_push_idx;
  logic [dps_pkg::NODE_W-1:0]  wr_push_node;

  assign in_ready_o = (state_q == dps_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign top_idx    = dps_pkg::NODE_W'(depth_q - 1'b1);
  assign push_idx   = depth_q[dps_pkg::NODE_W-1:0];
  assign rd_idx     = (state_q == dps_pkg::ST_EMIT) ? emit_idx_q : top_idx;
  assign rd_node    = stk_node_q[rd_idx];
  assign rd_scan    = stk_scan_q[rd_idx];
  assign emit_last  = !found_q || (emit_idx_q == '0);

  dps_edge_unit u_edge (
    .adj_i     (adj_i),
    .visited_i (visited_q),
    .node_i    (rd_node),
    .col_i     (rd_scan),
    .target_i  (target_q),
    .res_o     (eres)
  );

  always_comb begin
    item_o.valid     = (state_q == dps_pkg::ST_EMIT);
    item_o.path_node = found_q ? rd_node : '0;
    item_o.found     = found_q;
    item_o.last      = emit_last;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      dps_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = (start_i == target_i) ? dps_pkg::ST_EMIT : dps_pkg::ST_SEARCH;
        end
      end
      dps_pkg::ST_SEARCH: begin
        if (eres.hit) begin
          state_d = dps_pkg::ST_EMIT;
        end else if (eres.col_done && depth_q == dps_pkg::DEPTH_W'(1)) begin
          state_d = dps_pkg::ST_EMIT;
        end
      end
      dps_pkg::ST_EMIT: begin
        if (take_i && emit_last) begin
          state_d = dps_pkg::ST_IDLE;
        end
      end
      default: state_d = dps_pkg::ST_IDLE;
    endcase
  end

  // Datapath controls.
  always_comb begin
    depth_d      = depth_q;
    visited_d    = visited_q;
    target_d     = target_q;
    emit_idx_d   = emit_idx_q;
    found_d      = found_q;
    wr_scan_en   = 1'b0;
    wr_push_en   = 1'b0;
    wr_push_idx  = push_idx;
    wr_push_node = rd_scan[dps_pkg::NODE_W-1:0];
    case (state_q)
      dps_pkg::ST_IDLE: begin
        if (accept) begin
          depth_d      = dps_pkg::DEPTH_W'(1);
          visited_d    = dps_pkg::NODES'(1) << start_i;
          target_d     = target_i;
          emit_idx_d   = '0;
          found_d      = (start_i == target_i);
          wr_push_en   = 1'b1;
          wr_push_idx  = '0;
          wr_push_node = start_i;
        end
      end
      dps_pkg::ST_SEARCH: begin
        if (eres.col_done) begin
          depth_d = depth_q - 1'b1;
          found_d = 1'b0;
        end else begin
          wr_scan_en = 1'b1;
          if (eres.push) begin
            wr_push_en = 1'b1;
            depth_d    = depth_q + 1'b1;
            visited_d  = visited_q | (dps_pkg::NODES'(1) << rd_scan[dps_pkg::NODE_W-1:0]);
            emit_idx_d = push_idx;
            found_d    = eres.hit;
          end
        end
      end
      dps_pkg::ST_EMIT: begin
        if (take_i && !emit_last) begin
          emit_idx_d = emit_idx_q - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= dps_pkg::ST_IDLE;
      depth_q    <= '0;
      visited_q  <= '0;
      found_q    <= 1'b0;
      emit_idx_q <= '0;
    end else begin
      state_q    <= state_d;
      depth_q    <= depth_d;
      visited_q  <= visited_d;
      found_q    <= found_d;
      emit_idx_q <= emit_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    target_q <= target_d;
    if (wr_scan_en) begin
      stk_scan_q[top_idx] <= rd_scan + 1'b1;
    end
    if (wr_push_en) begin
      stk_node_q[wr_push_idx] <= wr_push_node;
      stk_scan_q[wr_push_idx] <= '0;
    end
  end

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= dps_pkg::DEPTH_W'(dps_pkg::NODES))
    else $error("stack depth above node count");

  a_search_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dps_pkg::ST_SEARCH) |-> (depth_q != '0))
    else $error("search running on an empty stack");

  a_start_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (visited_q == (dps_pkg::NODES'(1) << $past(start_i))))
    else $error("start node not marked after request");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_o.valid && take_i && item_o.last) |=> (state_q == dps_pkg::ST_IDLE))
    else $error("query did not end after last result");

  a_emit_in_stack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_o.valid && found_q) |-> (emit_idx_q < depth_q))
    else $error("emit index outside the stack");

endmodule

// ===== rtl/dfs_path_search_unit.sv =====
// Top level of the depth-first path search unit: ports, register and output stage.
//
// Channel   | Direction | Contents
// ----------+-----------+-----------------------------------------------------
// s_axis    | in        | one request: start node and target node
// m_axis    | out       | path nodes, target first, start last; tlast on final
// APB       | in/out    | register 0 at byte address 0: adjacency_bits (64 bit)
//
// A request is loaded, then the search loop runs its neighbor tests and stack pops,
// with the shared edge unit testing one matrix cell per cycle, and then the results
// are emitted as the output register takes them.
// Reset clears the sequencer, the visited marks and the adjacency register.
// The output register lets a new request enter while the last result waits, and
// a stalled m_axis holds the search in its emit phase until results are taken.
module dfs_path_search_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB-style configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  // Request stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [2:0] start_node, [5:3] target_node, [7:6] zero
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [2:0] path_node, [7:3] zero
  output logic        m_axis_tuser,   // [0] found
  output logic        m_axis_tlast
);

  logic [dps_pkg::ADJ_W-1:0]  adj_q;
  logic                       cfg_wr;
  logic                       reg_sel;

  dps_pkg::emit_t             item;
  logic                       take;
  logic                       out_valid_q, out_valid_d;
  logic [dps_pkg::NODE_W-1:0] out_node_q;
  logic                       out_found_q;
  logic                       out_last_q;

  // Only register 0 exists; other addresses read as zero and ignore writes.
  assign pready  = 1'b1;
  assign reg_sel = (paddr == 4'd0);
  assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
  assign prdata  = reg_sel ? adj_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adj_q <= '0;
    end else if (cfg_wr) begin
      adj_q <= pwdata;
    end
  end

  dps_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adj_i      (adj_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .start_i    (s_axis_tdata[2:0]),
    .target_i   (s_axis_tdata[5:3]),
    .item_o     (item),
    .take_i     (take)
  );

  // The output register loads whenever it is empty or being drained.
  assign take        = item.valid && (!out_valid_q || m_axis_tready);
  assign out_valid_d = take || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_node_q  <= item.path_node;
      out_found_q <= item.found;
      out_last_q  <= item.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_node_q};
  assign m_axis_tuser  = out_found_q;
  assign m_axis_tlast  = out_last_q;

endmodule
